FILE: src/lfs_pkg.sv
// shared types and constants of the link frame sequencer
`timescale 1ns / 1ps

package lfs_pkg;

    // word kind carried on the input tuser
    typedef enum logic [1:0] {
        MODE_XFER  = 2'd0,  // transfer done, four slot halfwords arrived
        MODE_WRITE = 2'd1,  // write one word of the outgoing packet
        MODE_POST  = 2'd2,  // post the outgoing packet
        MODE_READ  = 2'd3   // read one word of the last received frame
    } mode_t;

    // slot 0 content that closes a frame
    localparam logic [15:0] IDLE_WORD = 16'hFEFE;

    localparam int unsigned HALF_W   = 16;
    localparam int unsigned S_DATA_W = 96;
    localparam int unsigned M_DATA_W = 40;

    // result flags carried from the update stage to the output stage
    typedef struct packed {
        logic       send_valid;
        logic       error_flag;
        logic       frame_closed;
        logic       packet_arrived;
        logic       lower_start;
        logic       stop_timer;
        logic       restart_transfer;
        logic       read_hit;
        logic [1:0] read_slot;
    } mid_t;

endpackage

FILE: src/link_frame_sequencer.sv
// top level of the link frame sequencer: framing counters, bank swap and word stores
`timescale 1ns / 1ps

// channel   dir  handshake                   payload
// s_        in   s_tvalid / s_tready         s_tdata (96), s_tuser (2) = mode
// m_        out  m_tvalid / m_tready         m_tdata (40)
// cfg_      in   cfg_valid / cfg_ready       cfg_data (8) = link_active
//
// one word in, one word out; a new word is taken every cycle when the output drains
// the result reaches m_tdata through the input register, then state update with store read
// into the middle stage, then the output register
// the store reads are registered, so the update stage issues them and the output stage muxes
// aresetn (synchronous, active low) sets both counters to frame_words+1, banks and flags to 0
// word stores are not cleared; an entry that was never written reads as anything
// a stall on m_tready holds the output word; earlier stages fill behind it, then s_tready drops
// cfg_ready is always high

module link_frame_sequencer #(
    parameter int FRAME_WORDS = 10,
    parameter int SLOTS       = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] slot_word0, [31:16] slot_word1, [47:32] slot_word2, [63:48] slot_word3,
    // [64] line_error, [65] start_bit_set, [69:66] word_index, [71:70] slot_select,
    // [87:72] write_value, [88] clear_arrived, [95:89] zero
    input  logic [lfs_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  logic [1:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] send_word, [16] send_valid, [17] error_flag, [18] frame_closed,
    // [19] packet_arrived, [20] lower_start, [21] stop_timer, [22] restart_transfer,
    // [38:23] read_data, [39] zero
    output logic [lfs_pkg::M_DATA_W-1:0]    m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data
);

    // counter widths: send position 0..frame_words+1, receive position -1..frame_words+1
    localparam int CNT_W  = $clog2(FRAME_WORDS + 2);
    localparam int RC_W   = CNT_W + 1;
    localparam int ADDR_W = $clog2(2 * FRAME_WORDS);
    localparam int SEL_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = 2 * FRAME_WORDS;

    localparam logic [CNT_W-1:0]        SC_FULL = CNT_W'(FRAME_WORDS);
    localparam logic signed [RC_W-1:0]  RC_FULL = RC_W'(FRAME_WORDS);
    localparam logic signed [RC_W-1:0]  RC_LAST = RC_W'(FRAME_WORDS - 1);
    localparam logic signed [RC_W-1:0]  RC_IDLE = RC_W'(FRAME_WORDS + 1);
    localparam logic signed [RC_W-1:0]  RC_ZERO = '0;
    localparam logic signed [RC_W-1:0]  RC_ONE  = RC_W'(1);
    localparam logic signed [RC_W-1:0]  RC_NEG1 = '1;
    localparam logic [CNT_W-1:0]        SC_IDLE = CNT_W'(FRAME_WORDS + 1);
    localparam logic [ADDR_W-1:0]       BANK_OFS = ADDR_W'(FRAME_WORDS);

    typedef logic [SLOTS-1:0][lfs_pkg::HALF_W-1:0] row_t;

    // store address: bank selects the upper half
    function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                     input logic [ADDR_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = bank ? BANK_OFS : '0;
        return base + pos;
    endfunction

    // configuration
    logic [7:0] link_active_reg;

    // framing state
    logic [CNT_W-1:0]       send_count_reg, send_count_next;
    logic signed [RC_W-1:0] recv_count_reg, recv_count_next;
    logic                   tx_bank_reg, tx_bank_next;
    logic                   rx_bank_reg, rx_bank_next;
    logic                   posted_reg, posted_next;
    logic                   arrived_reg, arrived_next;

    // stages
    logic                           in_valid_reg;
    logic [lfs_pkg::S_DATA_W-1:0]   in_data_reg;
    logic [1:0]                     in_user_reg;
    logic                           mid_valid_reg;
    lfs_pkg::mid_t                  mid_reg, mid_next;
    logic                           out_valid_reg;
    logic [lfs_pkg::M_DATA_W-1:0]   out_data_reg, out_data_next;

    // word stores
    logic [lfs_pkg::HALF_W-1:0] send_mem [DEPTH];
    row_t                       recv_mem [DEPTH];
    logic [lfs_pkg::HALF_W-1:0] send_rd_reg;
    row_t                       recv_rd_reg;
    logic [ADDR_W-1:0]          send_waddr, send_raddr, recv_waddr, recv_raddr;
    logic                       send_we, recv_we;
    row_t                       recv_wdata;

    // handshake chain
    logic out_free, mid_move, mid_free, in_move, in_free;

    assign out_free = !out_valid_reg || m_tready;
    assign mid_move = mid_valid_reg && out_free;
    assign mid_free = !mid_valid_reg || mid_move;
    assign in_move  = in_valid_reg && mid_free;
    assign in_free  = !in_valid_reg || in_move;

    assign s_tready  = in_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // input word fields
    lfs_pkg::mode_t                 in_mode;
    logic [lfs_pkg::HALF_W-1:0]     slot_word [4];
    logic                           line_error, start_bit_set, clear_arrived;
    logic [3:0]                     word_index;
    logic [1:0]                     slot_select;
    logic [lfs_pkg::HALF_W-1:0]     write_value;
    logic                           widx_ok, sel_ok;

    always_comb begin
        in_mode       = lfs_pkg::mode_t'(in_user_reg);
        slot_word[0]  = in_data_reg[15:0];
        slot_word[1]  = in_data_reg[31:16];
        slot_word[2]  = in_data_reg[47:32];
        slot_word[3]  = in_data_reg[63:48];
        line_error    = in_data_reg[64];
        start_bit_set = in_data_reg[65];
        word_index    = in_data_reg[69:66];
        slot_select   = in_data_reg[71:70];
        write_value   = in_data_reg[87:72];
        clear_arrived = in_data_reg[88];
        widx_ok       = {28'd0, word_index} < 32'(FRAME_WORDS);
        sel_ok        = {30'd0, slot_select} < 32'(SLOTS);
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            recv_wdata[i] = slot_word[i];
        end
    end

    // state update for the word in the input register
    logic                   close_hit;
    logic [CNT_W-1:0]       sc_mid;
    logic signed [RC_W-1:0] rc_mid;

    always_comb begin
        send_count_next = send_count_reg;
        recv_count_next = recv_count_reg;
        tx_bank_next    = tx_bank_reg;
        rx_bank_next    = rx_bank_reg;
        posted_next     = posted_reg;
        arrived_next    = arrived_reg;
        mid_next        = '0;
        close_hit       = 1'b0;
        sc_mid          = send_count_reg;
        rc_mid          = recv_count_reg;
        send_we         = 1'b0;
        recv_we         = 1'b0;
        send_waddr      = store_addr(!tx_bank_reg, ADDR_W'(word_index));
        recv_raddr      = store_addr(!rx_bank_reg, ADDR_W'(word_index));
        send_raddr      = '0;
        recv_waddr      = '0;

        case (in_mode)
            lfs_pkg::MODE_XFER: begin
                // idle word after the last slot word closes the frame
                close_hit = (slot_word[0] == lfs_pkg::IDLE_WORD) && (recv_count_reg > RC_LAST);
                if (close_hit) begin
                    rc_mid       = RC_NEG1;
                    rx_bank_next = !rx_bank_reg;
                    if (posted_reg) begin
                        tx_bank_next = !tx_bank_reg;
                        posted_next  = 1'b0;
                        sc_mid       = '0;
                    end
                end
                // next send word from the bank being sent
                mid_next.send_valid = sc_mid < SC_FULL;
                send_raddr          = store_addr(tx_bank_next, ADDR_W'(sc_mid));
                send_count_next     = (sc_mid <= SC_FULL) ? sc_mid + CNT_W'(1) : sc_mid;
                // slot words go in while the receive position is inside the frame
                recv_waddr = store_addr(rx_bank_next, ADDR_W'(rc_mid[CNT_W-1:0]));
                if (rc_mid >= RC_ZERO && rc_mid < RC_FULL) begin
                    recv_we = 1'b1;
                    if (rc_mid == RC_LAST) begin
                        arrived_next = 1'b1;
                    end
                end
                recv_count_next = (rc_mid <= RC_FULL) ? rc_mid + RC_ONE : rc_mid;

                mid_next.error_flag       = line_error;
                mid_next.frame_closed     = close_hit;
                mid_next.lower_start      = (link_active_reg == 8'd1) && start_bit_set;
                mid_next.stop_timer       = link_active_reg != 8'd0;
                mid_next.restart_transfer = (send_count_next <= SC_FULL)
                                            && (link_active_reg != 8'd0);
            end
            lfs_pkg::MODE_WRITE: begin
                // host writes the bank not being sent
                send_we = widx_ok;
            end
            lfs_pkg::MODE_POST: begin
                posted_next = 1'b1;
            end
            lfs_pkg::MODE_READ: begin
                // host reads the bank not being filled
                mid_next.read_hit  = widx_ok && sel_ok;
                mid_next.read_slot = slot_select;
                if (clear_arrived) begin
                    arrived_next = 1'b0;
                end
            end
            default: begin
            end
        endcase

        mid_next.packet_arrived = arrived_next;
    end

    // output word: store read data joins the flags here
    logic [lfs_pkg::HALF_W-1:0] send_word_sel, read_data_sel;

    always_comb begin
        send_word_sel = mid_reg.send_valid ? send_rd_reg : '0;
        read_data_sel = mid_reg.read_hit ? recv_rd_reg[mid_reg.read_slot[SEL_W-1:0]] : '0;
        out_data_next = {1'b0, read_data_sel,
                         mid_reg.restart_transfer, mid_reg.stop_timer, mid_reg.lower_start,
                         mid_reg.packet_arrived, mid_reg.frame_closed, mid_reg.error_flag,
                         mid_reg.send_valid, send_word_sel};
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_active_reg <= '0;
            send_count_reg  <= SC_IDLE;
            recv_count_reg  <= RC_IDLE;
            tx_bank_reg     <= 1'b0;
            rx_bank_reg     <= 1'b0;
            posted_reg      <= 1'b0;
            arrived_reg     <= 1'b0;
            in_valid_reg    <= 1'b0;
            mid_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                link_active_reg <= cfg_data;
            end
            if (in_move) begin
                send_count_reg <= send_count_next;
                recv_count_reg <= recv_count_next;
                tx_bank_reg    <= tx_bank_next;
                rx_bank_reg    <= rx_bank_next;
                posted_reg     <= posted_next;
                arrived_reg    <= arrived_next;
            end
            if (in_free) begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_free) begin
                mid_valid_reg <= in_move;
            end
            if (out_free) begin
                out_valid_reg <= mid_move;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_free && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (in_move) begin
            mid_reg <= mid_next;
        end
        if (mid_move) begin
            out_data_reg <= out_data_next;
        end
    end

    // send store: host writes, transfer reads
    always_ff @(posedge aclk) begin
        if (in_move && send_we) begin
            send_mem[send_waddr] <= write_value;
        end
        if (in_move) begin
            send_rd_reg <= send_mem[send_raddr];
        end
    end

    // receive store: one row of slot words per frame position
    always_ff @(posedge aclk) begin
        if (in_move && recv_we) begin
            recv_mem[recv_waddr] <= recv_wdata;
        end
        if (in_move) begin
            recv_rd_reg <= recv_mem[recv_raddr];
        end
    end

endmodule

FILE: tb/tb_link_frame_sequencer.sv
// self-checking testbench of the link frame sequencer: random and directed words, scoreboard
`timescale 1ns / 1ps

module tb_link_frame_sequencer;

    localparam int FRAME_WORDS  = 10;
    localparam int SLOTS        = 4;
    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 800;
    localparam int PHASES       = 5;

    // input word as it sits on s_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic        clr;
        logic [15:0] wval;
        logic [1:0]  sel;
        logic [3:0]  widx;
        logic        start_set;
        logic        line_err;
        logic [15:0] slot3;
        logic [15:0] slot2;
        logic [15:0] slot1;
        logic [15:0] slot0;
    } xfer_word_t;

    // result word as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic        pad;
        logic [15:0] read_data;
        logic        restart;
        logic        stop_timer;
        logic        lower_start;
        logic        arrived;
        logic        closed;
        logic        err;
        logic        send_valid;
        logic [15:0] send_word;
    } result_t;

    // mirrors the framing state and queues the result each accepted word must give
    class link_frame_checker;
        logic [7:0]  link_active;
        int          tx_pos;
        int          rx_pos;
        int          tx_bank;
        int          rx_bank;
        bit          posted;
        bit          arrived;
        logic [15:0] tx_mem [2*FRAME_WORDS];
        logic [15:0] rx_mem [2*SLOTS*FRAME_WORDS];
        bit          tx_written [2*FRAME_WORDS];
        bit          rx_written [2*SLOTS*FRAME_WORDS];
        result_t     due_results [$];
        int          errors;
        int          checked;
        int          closes;
        int          sent;
        int          reads;

        function new();
            link_active = 8'd0;
            tx_pos      = FRAME_WORDS + 1;
            rx_pos      = FRAME_WORDS + 1;
            tx_bank     = 0;
            rx_bank     = 0;
            posted      = 1'b0;
            arrived     = 1'b0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit host_bank_full();
            for (int i = 0; i < FRAME_WORDS; i++)
                if (!tx_written[(1 - tx_bank) * FRAME_WORDS + i]) return 1'b0;
            return 1'b1;
        endfunction

        function bit rx_ready(int sel, int idx);
            return rx_written[((1 - rx_bank) * SLOTS + sel) * FRAME_WORDS + idx];
        endfunction

        function void take_event(lfs_pkg::mode_t m, xfer_word_t w);
            result_t     r;
            logic [15:0] slot_w [SLOTS];
            int          k;
            r = '0;
            case (m)
                lfs_pkg::MODE_XFER: begin
                    slot_w[0] = w.slot0;
                    slot_w[1] = w.slot1;
                    slot_w[2] = w.slot2;
                    slot_w[3] = w.slot3;
                    r.err         = w.line_err;
                    r.lower_start = (link_active == 8'd1) && w.start_set;
                    // idle word past the last word closes the frame
                    if (w.slot0 == lfs_pkg::IDLE_WORD && rx_pos > FRAME_WORDS - 1) begin
                        rx_pos  = -1;
                        rx_bank = 1 - rx_bank;
                        if (posted) begin
                            tx_bank = 1 - tx_bank;
                            posted  = 1'b0;
                            tx_pos  = 0;
                        end
                        r.closed = 1'b1;
                        closes++;
                    end
                    if (tx_pos <= FRAME_WORDS - 1) begin
                        r.send_word  = tx_mem[tx_bank * FRAME_WORDS + tx_pos];
                        r.send_valid = 1'b1;
                        sent++;
                    end
                    if (tx_pos <= FRAME_WORDS) tx_pos++;
                    if (rx_pos >= 0 && rx_pos < FRAME_WORDS) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            k = (rx_bank * SLOTS + i) * FRAME_WORDS + rx_pos;
                            rx_mem[k]     = slot_w[i];
                            rx_written[k] = 1'b1;
                        end
                        if (rx_pos == FRAME_WORDS - 1) arrived = 1'b1;
                    end
                    if (rx_pos <= FRAME_WORDS) rx_pos++;
                    r.stop_timer = (link_active != 8'd0);
                    r.restart    = (tx_pos <= FRAME_WORDS) && (link_active != 8'd0);
                end
                lfs_pkg::MODE_WRITE: begin
                    if (w.widx < FRAME_WORDS) begin
                        k = (1 - tx_bank) * FRAME_WORDS + int'(w.widx);
                        tx_mem[k]     = w.wval;
                        tx_written[k] = 1'b1;
                    end
                end
                lfs_pkg::MODE_POST: posted = 1'b1;
                lfs_pkg::MODE_READ: begin
                    if (w.widx < FRAME_WORDS && w.sel < SLOTS) begin
                        r.read_data = rx_mem[((1 - rx_bank) * SLOTS + int'(w.sel)) * FRAME_WORDS
                                             + int'(w.widx)];
                        reads++;
                    end
                    if (w.clr) arrived = 1'b0;
                end
                default: begin
                end
            endcase
            r.arrived = arrived;
            due_results.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_output_word(result_t got);
            result_t want;
            checked++;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = due_results.pop_front();
                cmp("send_word", want.send_word, got.send_word);
                cmp("send_valid", want.send_valid, got.send_valid);
                cmp("error_flag", want.err, got.err);
                cmp("frame_closed", want.closed, got.closed);
                cmp("packet_arrived", want.arrived, got.arrived);
                cmp("lower_start", want.lower_start, got.lower_start);
                cmp("stop_timer", want.stop_timer, got.stop_timer);
                cmp("restart_transfer", want.restart, got.restart);
                cmp("read_data", want.read_data, got.read_data);
                cmp("pad", want.pad, got.pad);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    link_frame_checker tracker = new();
    bit rx_stalls = 1'b1;
    int cycles    = 0;
    int fed       = 0;
    int n_settings = 0;

    always #6 aclk = ~aclk;

    link_frame_sequencer #(
        .FRAME_WORDS(FRAME_WORDS),
        .SLOTS      (SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // result side: ready stretches broken by stall bursts
    initial begin : ready_gen
        int n;
        forever begin
            n = $urandom_range(1, 40);
            m_tready <= 1'b1;
            repeat (n) @(posedge aclk);
            if (rx_stalls && $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_output_word(result_t'(m_tdata));
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, tracker.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] rnd_half();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // mostly well-formed framing: closes once a frame is full, reads only stored words
    function automatic void pick_event(output lfs_pkg::mode_t m, output xfer_word_t w);
        int roll;
        int idx;
        w     = xfer_word_t'({$urandom(), $urandom(), $urandom()});
        w.pad = '0;
        roll  = $urandom_range(0, 99);
        idx   = 0;
        if (roll < 50) begin
            m       = lfs_pkg::MODE_XFER;
            w.slot0 = rnd_half();
            w.slot1 = rnd_half();
            w.slot2 = rnd_half();
            w.slot3 = rnd_half();
            if (tracker.rx_pos >= FRAME_WORDS) begin
                if ($urandom_range(0, 9) < 6) w.slot0 = lfs_pkg::IDLE_WORD;
            end else if ($urandom_range(0, 19) == 0) begin
                w.slot0 = lfs_pkg::IDLE_WORD;
            end
        end else if (roll < 72) begin
            m      = lfs_pkg::MODE_WRITE;
            w.widx = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
                                                : 4'($urandom_range(10, 15));
            w.wval = rnd_half();
        end else if (roll < 78) begin
            if (tracker.host_bank_full()) begin
                m = lfs_pkg::MODE_POST;
            end else begin
                // fill the host bank first so a swapped-in packet is fully written
                for (int i = FRAME_WORDS - 1; i >= 0; i--)
                    if (!tracker.tx_written[(1 - tracker.tx_bank) * FRAME_WORDS + i]) idx = i;
                m      = lfs_pkg::MODE_WRITE;
                w.widx = idx[3:0];
                w.wval = rnd_half();
            end
        end else begin
            m      = lfs_pkg::MODE_READ;
            w.widx = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
                                                : 4'($urandom_range(10, 15));
            if (w.widx < FRAME_WORDS && !tracker.rx_ready(int'(w.sel), int'(w.widx)))
                w.widx = 4'($urandom_range(10, 15));
            w.clr = ($urandom_range(0, 3) == 0);
        end
    endfunction

    task automatic push(input lfs_pkg::mode_t m, input xfer_word_t w);
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_event(m, w);
        fed++;
    endtask

    task automatic write_link(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.link_active = v;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic settle();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic run_directed();
        xfer_word_t w;
        // out of range read before anything is stored
        w = '0; w.widx = 4'd15; w.sel = 2'd3; w.clr = 1'b1;
        push(lfs_pkg::MODE_READ, w);
        // fill the host bank, extremes at both ends
        for (int i = 0; i < FRAME_WORDS; i++) begin
            w = '0;
            w.widx = i[3:0];
            w.wval = (i == 0) ? 16'h0000 : (i == FRAME_WORDS - 1) ? 16'hFFFF : 16'($urandom());
            push(lfs_pkg::MODE_WRITE, w);
        end
        push(lfs_pkg::MODE_POST, '0);
        // writes while posted: one out of range, one into the posted bank
        w = '0; w.widx = 4'd10; w.wval = 16'hFFFF;
        push(lfs_pkg::MODE_WRITE, w);
        w = '0; w.widx = 4'd4; w.wval = 16'hA5C3;
        push(lfs_pkg::MODE_WRITE, w);
        push(lfs_pkg::MODE_POST, '0);
        // idle word from reset position closes and swaps the posted packet in
        w = '0; w.slot0 = lfs_pkg::IDLE_WORD; w.line_err = 1'b1; w.start_set = 1'b1;
        push(lfs_pkg::MODE_XFER, w);
        w = '1; w.pad = '0; w.line_err = 1'b0;
        push(lfs_pkg::MODE_XFER, w);
        w = '0; w.line_err = 1'b1;
        push(lfs_pkg::MODE_XFER, w);
        // idle word inside a frame is plain data
        w = '0; w.slot0 = lfs_pkg::IDLE_WORD; w.slot3 = 16'hFFFF; w.start_set = 1'b1;
        push(lfs_pkg::MODE_XFER, w);
        w = '0; w.widx = 4'd12; w.sel = 2'd1;
        push(lfs_pkg::MODE_READ, w);
        s_tvalid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int gap_pct);
        lfs_pkg::mode_t m;
        xfer_word_t     w;
        for (int i = 0; i < count; i++) begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            pick_event(m, w);
            push(m, w);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin : main
        logic [7:0] link_values [PHASES];
        int         gap_pcts [PHASES];
        link_values = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h01};
        gap_pcts    = '{25, 0, 40, 15, 0};
        link_values[3] = 8'($urandom_range(2, 254));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        write_link(8'd1);
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_link(link_values[p]);
            // last phase runs flat out on both sides
            rx_stalls = (p != PHASES - 1);
            run_random(RANDOM_WORDS / PHASES, gap_pcts[p]);
        end
        settle();
        $display("fed %0d words over %0d link_active settings, checked %0d results",
                 fed, n_settings, tracker.checked);
        $display("saw %0d frame closes, %0d words sent, %0d stored words read back",
                 tracker.closes, tracker.sent, tracker.reads);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
